// ===== sv/cea_vbs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and widths for the cea-861 video block scanner
// no dependencies

package cea_vbs_pkg;

  localparam int ByteW   = 8;
  localparam int VicW    = 7;
  localparam int PosW    = 9;
  localparam int OffW    = 7;
  localparam int LenW    = 5;

  localparam logic [PosW-1:0] ExtCountPos = 9'd126;
  localparam logic [PosW-1:0] TagPos      = 9'd128;
  localparam logic [PosW-1:0] LimitPos    = 9'd130;
  localparam logic [PosW-1:0] DataStart   = 9'd132;
  localparam logic [PosW-1:0] BlockLast   = 9'd255;
  localparam logic [PosW-1:0] DumpFull    = 9'd256;

  localparam logic [OffW-1:0]  DefaultLimit = 7'd127;
  localparam logic [ByteW-1:0] CeaTag       = 8'h02;
  localparam logic [2:0]       VideoType    = 3'd2;

endpackage

// ===== sv/cea_vbs_in_if.sv =====
`timescale 1ns / 1ps
// input channel: one edid byte per beat with an end-of-dump mark
// depends on cea_vbs_pkg

interface cea_vbs_in_if
  import cea_vbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] edid_byte;
  logic             last_byte;

  modport source (output valid, output edid_byte, output last_byte, input ready);
  modport sink   (input valid, input edid_byte, input last_byte, output ready);
endinterface

// ===== sv/cea_vbs_out_if.sv =====
`timescale 1ns / 1ps
// result channel: one report beat per dump
// depends on cea_vbs_pkg

interface cea_vbs_out_if
  import cea_vbs_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            vic_supported;
  logic            has_video_block;
  logic            vic_listed;
  logic [VicW-1:0] native_vic;
  logic            cea_found;

  modport source (output valid, output vic_supported, output has_video_block,
                  output vic_listed, output native_vic, output cea_found, input ready);
  modport sink   (input valid, input vic_supported, input has_video_block,
                  input vic_listed, input native_vic, input cea_found, output ready);
endinterface

// ===== sv/cea861_video_block_scanner.sv =====
`timescale 1ns / 1ps
// cea-861 video data block scanner, top level
// depends on cea_vbs_pkg, cea_vbs_in_if, cea_vbs_out_if
//
// usage
//   din  : edid dump, one byte per beat, block 0 first; last_byte marks the
//          final byte of the dump and triggers one report beat on dout
//   dout : report with cea_found, has_video_block, vic_listed, native_vic
//          and the vic_supported verdict for the configured vic
//   cfg  : cfg_we/cfg_data write target_vic; write only between dumps
// timing
//   each byte updates the scan state in the cycle it is accepted, so one
//   byte per cycle is sustained while din.ready is high; the report appears
//   on dout in the cycle after the last byte is accepted (a single output register)
// stalls
//   din.ready stays high while the output register is empty or is being
//   drained; only a report held by a stalled receiver blocks input
// reset
//   rst (synchronous, active high) clears the scan state, drops any pending
//   report and sets target_vic to 0; no clearing pass is needed

module cea861_video_block_scanner
  import cea_vbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [VicW-1:0] cfg_data,
  cea_vbs_in_if.sink      din,
  cea_vbs_out_if.source   dout
);

  // config register
  logic [VicW-1:0] target_vic;

  // scan state
  logic [PosW-1:0] byte_position, byte_position_next;
  logic            extension_present, extension_present_next;
  logic            tag_matches, tag_matches_next;
  logic [OffW-1:0] walk_limit, walk_limit_next;
  logic [OffW-1:0] next_header_index, next_header_index_next;
  logic [LenW-1:0] block_bytes_left, block_bytes_left_next;
  logic            inside_video_block, inside_video_block_next;
  logic            walk_stopped, walk_stopped_next;
  logic            video_block_seen, video_block_seen_next;
  logic            vic_match_seen, vic_match_seen_next;
  logic [VicW-1:0] native_code, native_code_next;
  logic            native_seen, native_seen_next;

  // output register
  logic            out_valid;
  logic            rep_supported, rep_video, rep_listed, rep_cea;
  logic [VicW-1:0] rep_native;

  // per-beat helpers
  logic            in_acc;
  logic [PosW-1:0] off_full;
  logic [OffW-1:0] off;
  logic [LenW-1:0] hdr_len;
  logic [2:0]      hdr_type;
  logic [7:0]      off_p1;
  logic [7:0]      blk_end;
  logic            cea_now;
  logic            vdb_now;
  logic            listed_now;

  assign din.ready = !out_valid || dout.ready;
  assign in_acc    = din.valid && din.ready;

  // offset into the data block area, valid from byte 132 to byte 255
  assign off_full = byte_position - DataStart;
  assign off      = off_full[OffW-1:0];
  assign hdr_len  = din.edid_byte[LenW-1:0];
  assign hdr_type = din.edid_byte[7:5];
  assign off_p1   = {1'b0, off} + 8'd1;
  assign blk_end  = off_p1 + {3'b000, hdr_len};

  always_comb begin
    byte_position_next      = byte_position;
    extension_present_next  = extension_present;
    tag_matches_next        = tag_matches;
    walk_limit_next         = walk_limit;
    next_header_index_next  = next_header_index;
    block_bytes_left_next   = block_bytes_left;
    inside_video_block_next = inside_video_block;
    walk_stopped_next       = walk_stopped;
    video_block_seen_next   = video_block_seen;
    vic_match_seen_next     = vic_match_seen;
    native_code_next        = native_code;
    native_seen_next        = native_seen;

    if (byte_position == ExtCountPos) begin
      extension_present_next = (din.edid_byte != '0);
    end else if (byte_position == TagPos) begin
      tag_matches_next = (din.edid_byte == CeaTag);
    end else if (byte_position == LimitPos) begin
      // zero or anything above 127 falls back to the full block
      if (din.edid_byte == '0 || din.edid_byte[7]) begin
        walk_limit_next = DefaultLimit;
      end else begin
        walk_limit_next = din.edid_byte[OffW-1:0];
      end
    end else if (byte_position >= DataStart && byte_position <= BlockLast
                 && !walk_stopped) begin
      if (block_bytes_left != '0) begin
        // payload byte of the current data block
        if (inside_video_block) begin
          if (din.edid_byte[VicW-1:0] == target_vic) begin
            vic_match_seen_next = 1'b1;
          end
          if (din.edid_byte[7] && !native_seen) begin
            native_seen_next = 1'b1;
            native_code_next = din.edid_byte[VicW-1:0];
          end
        end
        block_bytes_left_next = block_bytes_left - 1'b1;
      end else if (off == next_header_index) begin
        // data block header: stop if it or its payload crosses the limit
        if (off_p1 >= {1'b0, walk_limit} || blk_end > {1'b0, walk_limit}) begin
          walk_stopped_next = 1'b1;
        end else begin
          inside_video_block_next = (hdr_type == VideoType);
          if (hdr_type == VideoType && hdr_len != '0) begin
            video_block_seen_next = 1'b1;
          end
          block_bytes_left_next  = hdr_len;
          next_header_index_next = blk_end[OffW-1:0];
        end
      end
    end

    if (byte_position != DumpFull) begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  // report terms from the state as it stands after this byte
  assign cea_now    = byte_position_next[PosW-1] && extension_present_next && tag_matches_next;
  assign vdb_now    = cea_now && video_block_seen_next;
  assign listed_now = cea_now && vic_match_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_vic <= '0;
    end else if (cfg_we) begin
      target_vic <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_acc && din.last_byte)) begin
      byte_position      <= '0;
      extension_present  <= 1'b0;
      tag_matches        <= 1'b0;
      walk_limit         <= DefaultLimit;
      next_header_index  <= '0;
      block_bytes_left   <= '0;
      inside_video_block <= 1'b0;
      walk_stopped       <= 1'b0;
      video_block_seen   <= 1'b0;
      vic_match_seen     <= 1'b0;
      native_code        <= '0;
      native_seen        <= 1'b0;
    end else if (in_acc) begin
      byte_position      <= byte_position_next;
      extension_present  <= extension_present_next;
      tag_matches        <= tag_matches_next;
      walk_limit         <= walk_limit_next;
      next_header_index  <= next_header_index_next;
      block_bytes_left   <= block_bytes_left_next;
      inside_video_block <= inside_video_block_next;
      walk_stopped       <= walk_stopped_next;
      video_block_seen   <= video_block_seen_next;
      vic_match_seen     <= vic_match_seen_next;
      native_code        <= native_code_next;
      native_seen        <= native_seen_next;
    end
  end

  // output register: loads on the last byte, drains on dout.ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && din.last_byte) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && din.last_byte) begin
      rep_supported <= (target_vic == '0) || !vdb_now || listed_now;
      rep_video     <= vdb_now;
      rep_listed    <= listed_now;
      rep_native    <= (cea_now && native_seen_next) ? native_code_next : '0;
      rep_cea       <= cea_now;
    end
  end

  assign dout.valid           = out_valid;
  assign dout.vic_supported   = rep_supported;
  assign dout.has_video_block = rep_video;
  assign dout.vic_listed      = rep_listed;
  assign dout.native_vic      = rep_native;
  assign dout.cea_found       = rep_cea;

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= DumpFull)
    else $error("byte position beyond full dump");

  a_limit_nonzero: assert property (@(posedge clk) disable iff (rst)
    walk_limit != '0)
    else $error("walk limit is zero");

  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc && din.last_byte))
    else $error("report without a last byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && din.last_byte |=> byte_position == '0 && !video_block_seen)
    else $error("scan state not cleared after report");

  a_report_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rep_cea |-> !rep_video && !rep_listed && rep_native == '0)
    else $error("report fields set without a cea block");

endmodule
